>>> hdl/sorted_set_table_top_assert.svh
// Assertion macros of the sorted set table top level.
`ifndef SORTED_SET_TABLE_TOP_ASSERT_SVH
`define SORTED_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted set table check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted set table check failed");

`endif

>>> hdl/sst_pkg.sv
// Shared constants, codes and types of the sorted set table.
`timescale 1ns / 1ps

package sst_pkg;

  // Storage geometry.
  localparam int DEPTH  = 128;
  localparam int KEY_W  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int RANK_W = 7;
  localparam int CNT_W  = 8;
  localparam int CAP_W  = 8;

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_RANK   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Request operands broadcast to every cell.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } sst_bcast_t;

  // Per-cell compare results returned to the top level.
  typedef struct packed {
    logic             eq;
    logic             rank_hit;
    logic [KEY_W-1:0] rd_key;
  } sst_flags_t;

endpackage

>>> hdl/sorted_set_table_top.sv
// Top level of the sorted set table: request and result registers, cell chain.
`timescale 1ns / 1ps
//
// Keeps up to 128 distinct 16-bit keys in ascending order in a chain of cells.
// Requests arrive on the s_axis channel: tuser carries the request type
// (insert, lookup, read by rank), tdata the key and the rank. Each request
// gives one result transfer on m_axis with hit, status, element and count.
// The capacity register is written through the cfg channel, which is always
// ready; write it only while no request is in flight.
// A request is held in the request register until it is executed, and its
// result is then presented on m_axis from the output register.
// Throughput: one request per cycle; every cell compares its key with the
// broadcast key in parallel and an insert shifts the chain by one.
// A stalled receiver holds the result in the output register; one request
// waits in the input register and s_axis_tready drops until the result moves.
// Reset empties the set (count zero) and sets the capacity to 100; it takes
// effect at once, with no clearing pass.
//

module sorted_set_table_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Request channel.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [15:0] key, [22:16] rank, [23] zero.
  input  logic [23:0]               s_axis_tdata,
  // [1:0] req_type.
  input  logic [1:0]                s_axis_tuser,
  // Result channel.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] hit, [2:1] status, [18:3] element, [26:19] count, [31:27] zero.
  output logic [31:0]               m_axis_tdata,
  // Capacity write channel.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sst_pkg::CAP_W-1:0] cfg_data_i
);

  localparam int DEPTH = sst_pkg::DEPTH;
  localparam int KEY_W = sst_pkg::KEY_W;
  localparam int CNT_W = sst_pkg::CNT_W;

  // Request register.
  logic                       busy_q;
  logic [1:0]                 req_q;
  logic [KEY_W-1:0]           key_q;
  logic [sst_pkg::RANK_W-1:0] rank_q;

  // State and result registers.
  logic [CNT_W-1:0]           count_q;
  logic [sst_pkg::CAP_W-1:0]  cap_q;
  logic                       out_valid_q;
  logic [31:0]                out_data_q;

  logic                       s_fire, exec_fire, ins_en, full;
  logic                       present, rank_found;
  logic [KEY_W-1:0]           element;
  logic                       hit_r;
  logic [1:0]                 status_r;
  logic [KEY_W-1:0]           element_r;
  logic [CNT_W-1:0]           count_r;

  sst_pkg::sst_bcast_t        bcast;
  logic [KEY_W-1:0]           key_w   [DEPTH];
  logic                       lt_w    [DEPTH];
  logic                       valid_w [DEPTH];
  sst_pkg::sst_flags_t        flags_w [DEPTH];
  logic [DEPTH-1:0]           valid_vec;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = busy_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || exec_fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  assign bcast.key  = key_q;
  assign bcast.rank = rank_q;

  // Chain of cells; cell zero sees a virtual left neighbor that is smaller
  // than any key, so it takes the new key whenever its own key is not smaller.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      sst_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .bcast_i     (bcast),
        .ins_i       (ins_en),
        .idx_i       (sst_pkg::IDX_W'(i)),
        .prev_key_i  ('0),
        .prev_lt_i   (1'b1),
        .prev_valid_i(1'b1),
        .key_o       (key_w[i]),
        .lt_o        (lt_w[i]),
        .valid_o     (valid_w[i]),
        .flags_o     (flags_w[i])
      );
    end else begin : g_rest
      sst_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .bcast_i     (bcast),
        .ins_i       (ins_en),
        .idx_i       (sst_pkg::IDX_W'(i)),
        .prev_key_i  (key_w[i-1]),
        .prev_lt_i   (lt_w[i-1]),
        .prev_valid_i(valid_w[i-1]),
        .key_o       (key_w[i]),
        .lt_o        (lt_w[i]),
        .valid_o     (valid_w[i]),
        .flags_o     (flags_w[i])
      );
    end
    assign valid_vec[i] = valid_w[i];
  end

  // Gather match flags and the selected element from all cells.
  always_comb begin
    present    = 1'b0;
    rank_found = 1'b0;
    element    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      present    = present    | flags_w[i].eq;
      rank_found = rank_found | flags_w[i].rank_hit;
      element    = element    | flags_w[i].rd_key;
    end
  end

  // The table is full at the configured capacity or at its depth.
  assign full   = (count_q >= CNT_W'(cap_q)) || (count_q >= CNT_W'(DEPTH));
  assign ins_en = exec_fire && (req_q == sst_pkg::REQ_INSERT) && !present && !full;

  // Result fields for the request being executed.
  always_comb begin
    hit_r     = 1'b0;
    status_r  = sst_pkg::ST_DONE;
    element_r = '0;
    count_r   = count_q + CNT_W'(ins_en);
    case (req_q)
      sst_pkg::REQ_INSERT: begin
        hit_r = present;
        if (!present && full) begin
          status_r = sst_pkg::ST_FULL;
        end
      end
      sst_pkg::REQ_LOOKUP: begin
        hit_r = present;
      end
      sst_pkg::REQ_RANK: begin
        if (rank_found) begin
          element_r = element;
        end else begin
          status_r = sst_pkg::ST_RANGE;
        end
      end
      default: begin
        hit_r = 1'b0;
      end
    endcase
  end

  // Control state: request slot, result slot, count and capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      cap_q       <= sst_pkg::CAP_W'(100);
    end else begin
      if (s_fire) begin
        busy_q <= 1'b1;
      end else if (exec_fire) begin
        busy_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      count_q <= count_r;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_q  <= s_axis_tuser;
      key_q  <= s_axis_tdata[15:0];
      rank_q <= s_axis_tdata[22:16];
    end
    if (exec_fire) begin
      out_data_q <= {5'd0, count_r, element_r, status_r, hit_r};
    end
  end

  // Checks on the cell chain and the count.
  `include "sorted_set_table_top_assert.svh"

  `SST_ASSERT_NOW(a_count_max, 1'b1, count_q <= CNT_W'(DEPTH))
  `SST_ASSERT_NOW(a_valid_count, 1'b1, $countones(valid_vec) == 32'(count_q))
  `SST_ASSERT_NEXT(a_count_hold, !ins_en, $stable(count_q))
  `SST_ASSERT_NEXT(a_count_step, ins_en, count_q == $past(count_q) + CNT_W'(1))

endmodule

>>> hdl/sst_cell.sv
// One storage cell of the sorted key chain, with its compare and shift logic.
`timescale 1ns / 1ps

module sst_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sst_pkg::sst_bcast_t       bcast_i,
  input  logic                      ins_i,
  input  logic [sst_pkg::IDX_W-1:0] idx_i,
  input  logic [sst_pkg::KEY_W-1:0] prev_key_i,
  input  logic                      prev_lt_i,
  input  logic                      prev_valid_i,
  output logic [sst_pkg::KEY_W-1:0] key_o,
  output logic                      lt_o,
  output logic                      valid_o,
  output sst_pkg::sst_flags_t       flags_o
);

  logic [sst_pkg::KEY_W-1:0] key_q, key_d;
  logic                      valid_q, valid_d;
  logic                      lt, eq, rank_hit;

  // Compare the held key against the broadcast request.
  assign lt       = valid_q && (key_q < bcast_i.key);
  assign eq       = valid_q && (key_q == bcast_i.key);
  assign rank_hit = valid_q &&
                    (sst_pkg::CNT_W'(idx_i) == sst_pkg::CNT_W'(bcast_i.rank));

  assign flags_o.eq       = eq;
  assign flags_o.rank_hit = rank_hit;
  assign flags_o.rd_key   = rank_hit ? key_q : '0;

  assign key_o   = key_q;
  assign lt_o    = lt;
  assign valid_o = valid_q;

  // On an insert, cells at or above the insert point take the new key or
  // their left neighbor's key; smaller keys stay in place.
  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ins_i && !lt) begin
      key_d   = prev_lt_i ? bcast_i.key : prev_key_i;
      valid_d = prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> test/tb_sorted_set_table_top.sv
// Self-checking testbench for the sorted set table: request driver, result checker, watchdog.
`timescale 1ns / 1ps

module tb_sorted_set_table_top;
  import sst_pkg::*;

  // The fourth request code has no function; the block answers it without a change.
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_AT_RESULT = 200;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]        kind;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } set_request_t;

  typedef struct packed {
    logic             hit;
    logic [1:0]       status;
    logic [KEY_W-1:0] element;
    logic [CNT_W-1:0] count;
  } set_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  cfg_data_i = '0;

  // Shadow copy of the table, updated in transfer order.
  logic [KEY_W-1:0]  held_keys [DEPTH];
  int                held_count = 0;
  int                cap_reg = 100;

  set_request_t      pend_q[$];
  set_result_t       exp_q[$];
  logic [KEY_W-1:0]  offered_keys[$];
  set_request_t      cur_req;
  int                send_wait = 0;
  int                sent_cnt = 0;
  int                recv_wait = 0;
  int                hold_left = 0;
  int                results_seen = 0;
  int                mismatches = 0;
  int                quiet_cycles = 0;

  sorted_set_table_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Applies one request to the shadow table and returns the result it must give.
  function automatic set_result_t apply_request(set_request_t req);
    set_result_t res;
    int limit;
    int pos;
    int i;
    res = '0;
    res.status = ST_DONE;
    limit = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    if (req.kind == REQ_INSERT || req.kind == REQ_LOOKUP) begin
      pos = 0;
      while (pos < held_count && held_keys[pos] < req.key) pos++;
      if (pos < held_count && held_keys[pos] == req.key) begin
        res.hit = 1'b1;
      end else if (req.kind == REQ_INSERT) begin
        if (held_count >= limit) begin
          res.status = ST_FULL;
        end else begin
          for (i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = req.key;
          held_count++;
        end
      end
    end else if (req.kind == REQ_RANK) begin
      if (req.rank < held_count) begin
        res.element = held_keys[req.rank];
      end else begin
        res.status = ST_RANGE;
      end
    end
    res.count = CNT_W'(held_count);
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch in %s: got %0h, expected %0h", field, got, want);
    mismatches++;
  endtask

  task automatic queue_request(logic [1:0] kind, logic [KEY_W-1:0] key,
                               logic [RANK_W-1:0] rank);
    set_request_t req;
    req.kind = kind;
    req.key = key;
    req.rank = rank;
    if (kind == REQ_INSERT) offered_keys.push_back(key);
    pend_q.push_back(req);
  endtask

  // Random requests; a share of the keys repeats earlier inserts so that hits occur.
  task automatic queue_random(int n, int ins_pct);
    logic [1:0] kind;
    logic [KEY_W-1:0] key;
    logic [RANK_W-1:0] rank;
    int roll;
    int span;
    int j;
    for (j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) kind = REQ_INSERT;
      else if (roll < ins_pct + (100 - ins_pct) / 2) kind = REQ_LOOKUP;
      else if (roll < 97) kind = REQ_RANK;
      else kind = REQ_NONE;
      if (offered_keys.size() > 0 && $urandom_range(0, 3) == 0) begin
        key = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
      end else if ($urandom_range(0, 7) == 0) begin
        key = KEY_W'($urandom_range(0, 15));
      end else begin
        key = KEY_W'($urandom);
      end
      span = (offered_keys.size() < 127) ? offered_keys.size() : 127;
      rank = $urandom_range(0, 1) ? RANK_W'($urandom) : RANK_W'($urandom_range(0, span));
      queue_request(kind, key, rank);
    end
  endtask

  // Waits until every queued request has been sent and answered.
  task automatic wait_idle();
    do @(posedge clk_i); while (pend_q.size() != 0 || s_axis_tvalid || exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CAP_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_reg = value;
  endtask

  // Request driver: one transfer per offered item, random gaps between items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_q.push_back(apply_request(cur_req));
        sent_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0 || pend_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end else begin
          cur_req = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, cur_req.rank, cur_req.key};
          s_axis_tuser <= cur_req.kind;
          send_wait = (sent_cnt % 64 < 40) ? $urandom_range(0, 11) : 0;
        end
      end
    end
  end

  // Result checker and receiver stalls, with one long hold-off to back up the input.
  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t got;
    set_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tdata[0];
        got.status = m_axis_tdata[2:1];
        got.element = m_axis_tdata[18:3];
        got.count = m_axis_tdata[26:19];
        if (exp_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          want = exp_q.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.element !== want.element) report_mismatch("element", got.element, want.element);
          if (got.count !== want.count) report_mismatch("count", got.count, want.count);
        end
        results_seen++;
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
        else recv_wait = (results_seen % 50 < 30) ? $urandom_range(0, 11) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_valid_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: key extremes, duplicates, misses, rank edges and the unused code.
    write_capacity(255);
    queue_request(REQ_INSERT, 16'h0000, 7'd0);
    queue_request(REQ_INSERT, 16'hFFFF, 7'd127);
    queue_request(REQ_INSERT, 16'h8000, 7'd0);
    queue_request(REQ_INSERT, 16'hFFFF, 7'd0);
    queue_request(REQ_LOOKUP, 16'hFFFF, 7'd0);
    queue_request(REQ_LOOKUP, 16'h1234, 7'd0);
    queue_request(REQ_LOOKUP, 16'h0000, 7'd0);
    queue_request(REQ_RANK, 16'hFFFF, 7'd0);
    queue_request(REQ_RANK, 16'h0000, 7'd2);
    queue_request(REQ_RANK, 16'h0000, 7'd3);
    queue_request(REQ_RANK, 16'h0000, 7'd127);
    queue_request(REQ_NONE, 16'hFFFF, 7'd127);
    queue_request(REQ_INSERT, 16'h5555, 7'd0);
    wait_idle();

    // Capacity below the count: new keys are rejected, held keys still hit.
    write_capacity(3);
    queue_request(REQ_INSERT, 16'h7777, 7'd0);
    queue_request(REQ_INSERT, 16'h8000, 7'd0);
    queue_request(REQ_RANK, 16'h0000, 7'd1);
    wait_idle();
    write_capacity(0);
    queue_request(REQ_INSERT, 16'h0001, 7'd0);
    queue_request(REQ_LOOKUP, 16'h5555, 7'd0);
    wait_idle();

    // Random phases; the large capacity lets the table fill to its depth.
    write_capacity(24);
    queue_random(80, 60);
    wait_idle();
    write_capacity(255);
    queue_random(260, 70);
    wait_idle();
    write_capacity(128);
    queue_random(120, 30);
    wait_idle();
    write_capacity(100);
    queue_random(40, 40);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
